/* src/egb_pkg.sv */
// ----------------------------------------------------------------------------
// egb_pkg
// Shared types, constants and codes of the elevation grid binner.
// ----------------------------------------------------------------------------
`default_nettype none

package egb_pkg;

    // grid bounds and cell memory geometry
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 128;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int GRID_W   = 8;

    localparam logic [GRID_W-1:0] MAX_COLS_B = GRID_W'(MAX_COLS);
    localparam logic [GRID_W-1:0] MAX_ROWS_B = GRID_W'(MAX_ROWS);

    // field constants
    localparam logic [7:0] GROUND_CLASS = 8'd2;
    localparam logic [3:0] FIRST_RETURN = 4'd1;

    // function codes of an input word
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // register map
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BIN_SIZE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRID_COLS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS = 3'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              mode;
        logic [15:0]       bin_size;
        logic [31:0]       origin_x;
        logic [31:0]       origin_y;
        logic [GRID_W-1:0] grid_cols;
        logic [GRID_W-1:0] grid_rows;
    } egb_cfg_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } egb_op_t;

    typedef struct packed {
        egb_op_t            op;
        logic [CELL_AW-1:0] idx;
        logic [31:0]        z;
        logic [7:0]         cls;
        logic [3:0]         ret;
    } egb_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } egb_q_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_DIV,
        F_PUSH
    } egb_front_state_t;

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_EXEC,
        B_CLEAR
    } egb_back_state_t;

endpackage

`default_nettype wire

/* src/egb_regs.sv */
// ----------------------------------------------------------------------------
// egb_regs
// APB register file holding mode, cell size, origin and grid shape.
// ----------------------------------------------------------------------------
`default_nettype none

module egb_regs
    import egb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output egb_cfg_t           cfg
);

    logic              mode_reg;
    logic [15:0]       bin_size_reg;
    logic [31:0]       origin_x_reg;
    logic [31:0]       origin_y_reg;
    logic [GRID_W-1:0] grid_cols_reg;
    logic [GRID_W-1:0] grid_rows_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            bin_size_reg  <= 16'd1000;
            origin_x_reg  <= 32'd0;
            origin_y_reg  <= 32'd0;
            grid_cols_reg <= MAX_COLS_B;
            grid_rows_reg <= MAX_ROWS_B;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:      mode_reg      <= pwdata[0];
                REG_BIN_SIZE:  bin_size_reg  <= pwdata[15:0];
                REG_ORIGIN_X:  origin_x_reg  <= pwdata;
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata;
                REG_GRID_COLS: grid_cols_reg <= pwdata[GRID_W-1:0];
                REG_GRID_ROWS: grid_rows_reg <= pwdata[GRID_W-1:0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_MODE:      prdata = {31'd0, mode_reg};
            REG_BIN_SIZE:  prdata = {16'd0, bin_size_reg};
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_ORIGIN_Y:  prdata = origin_y_reg;
            REG_GRID_COLS: prdata = {{(32-GRID_W){1'b0}}, grid_cols_reg};
            REG_GRID_ROWS: prdata = {{(32-GRID_W){1'b0}}, grid_rows_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = '{
        mode:      mode_reg,
        bin_size:  bin_size_reg,
        origin_x:  origin_x_reg,
        origin_y:  origin_y_reg,
        grid_cols: grid_cols_reg,
        grid_rows: grid_rows_reg
    };

endmodule

`default_nettype wire

/* src/egb_front.sv */
// ----------------------------------------------------------------------------
// egb_front
// Takes input words, bins points through a two-bit-per-cycle divider and
// hands classified operations to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module egb_front
    import egb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [1:0]         func,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [7:0]         point_class,
    input  logic [3:0]         return_number,
    input  logic [CELL_AW-1:0] read_cell,
    input  egb_cfg_t           cfg,
    input  egb_q_stat_t        q_stat,
    output logic               idle,
    output logic               push,
    output egb_entry_t         push_entry
);

    localparam int QUOT_W    = 8;
    localparam int DIV_STEPS = QUOT_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = 16 + QUOT_W;

    egb_front_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [1:0]         func_reg;
    logic [31:0]        z_reg;
    logic [7:0]         cls_reg;
    logic [3:0]         ret_reg;
    logic [CELL_AW-1:0] rc_reg;
    logic [32:0]        dx_reg, dy_reg;
    logic [REM_W-1:0]   rem_x_reg, rem_y_reg, dv_reg;
    logic [QUOT_W-1:0]  q_x_reg, q_y_reg;
    logic               drop_x_reg, drop_y_reg;

    logic [REM_W:0]   cls_x, cls_y;
    logic [REM_W+1:0] stp_x, stp_y;

    logic [GRID_W-1:0] eff_cols, eff_rows;
    logic [15:0]       row_base, idx_wide, area;
    logic              in_x, in_y, read_ok;
    egb_op_t           op;

    // drop flag and starting remainder of one axis; small negative offsets
    // land in bin zero
    function automatic logic [REM_W:0] classify(input logic [32:0] d,
                                                input logic [15:0] cs);
        logic [32:0]      sum;
        logic             in_neg;
        logic             big;
        logic             drop;
        logic [REM_W-1:0] rem;
        sum    = d + {17'd0, cs};
        in_neg = !sum[32] && (sum != 33'd0);
        big    = (d[31:REM_W] != '0) || (d[REM_W-1:0] >= {cs, {QUOT_W{1'b0}}});
        drop   = (cs == 16'd0) || (d[32] ? !in_neg : big);
        rem    = d[32] ? '0 : d[REM_W-1:0];
        return {drop, rem};
    endfunction

    // two restoring steps: quotient bits against dv and dv/2
    function automatic logic [REM_W+1:0] div_step(input logic [REM_W-1:0] rem,
                                                  input logic [REM_W-1:0] dv);
        logic [REM_W:0]   t1;
        logic [REM_W:0]   t2;
        logic [REM_W-1:0] r1;
        logic [REM_W-1:0] r2;
        logic             b1;
        logic             b2;
        t1 = {1'b0, rem} - {1'b0, dv};
        b1 = !t1[REM_W];
        r1 = b1 ? t1[REM_W-1:0] : rem;
        t2 = {1'b0, r1} - {2'b0, dv[REM_W-1:1]};
        b2 = !t2[REM_W];
        r2 = b2 ? t2[REM_W-1:0] : r1;
        return {b1, b2, r2};
    endfunction

    assign cls_x = classify(dx_reg, cfg.bin_size);
    assign cls_y = classify(dy_reg, cfg.bin_size);
    assign stp_x = div_step(rem_x_reg, dv_reg);
    assign stp_y = div_step(rem_y_reg, dv_reg);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and queue push
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    state_next = (func == FUNC_ADD) ? F_CLASS : F_PUSH;
                end
            end
            F_CLASS:
            begin
                state_next = F_DIV;
                step_next  = '0;
            end
            F_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == F_IDLE);

    // capture of the word, offsets and divider
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg <= func;
            z_reg    <= point_z;
            cls_reg  <= point_class;
            ret_reg  <= return_number;
            rc_reg   <= read_cell;
            dx_reg   <= {point_x[31], point_x} - {cfg.origin_x[31], cfg.origin_x};
            dy_reg   <= {point_y[31], point_y} - {cfg.origin_y[31], cfg.origin_y};
        end
        if (state_reg == F_CLASS)
        begin
            drop_x_reg <= cls_x[REM_W];
            drop_y_reg <= cls_y[REM_W];
            rem_x_reg  <= cls_x[REM_W-1:0];
            rem_y_reg  <= cls_y[REM_W-1:0];
            dv_reg     <= {1'b0, cfg.bin_size, {(QUOT_W-1){1'b0}}};
            q_x_reg    <= '0;
            q_y_reg    <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rem_x_reg <= stp_x[REM_W-1:0];
            rem_y_reg <= stp_y[REM_W-1:0];
            q_x_reg   <= {q_x_reg[QUOT_W-3:0], stp_x[REM_W+1:REM_W]};
            q_y_reg   <= {q_y_reg[QUOT_W-3:0], stp_y[REM_W+1:REM_W]};
            dv_reg    <= dv_reg >> 2;
        end
    end

    // grid bounds and cell index of the word
    always_comb
    begin
        eff_cols = (cfg.grid_cols > MAX_COLS_B) ? MAX_COLS_B : cfg.grid_cols;
        eff_rows = (cfg.grid_rows > MAX_ROWS_B) ? MAX_ROWS_B : cfg.grid_rows;
        in_x     = !drop_x_reg && (q_x_reg < eff_cols);
        in_y     = !drop_y_reg && (q_y_reg < eff_rows);
        row_base = 16'(q_y_reg) * 16'(eff_cols);
        idx_wide = row_base + 16'(q_x_reg);
        area     = 16'(eff_cols) * 16'(eff_rows);
        read_ok  = 16'(rc_reg) < area;
        case (func_reg)
            FUNC_ADD:   op = (in_x && in_y) ? OP_ADD : OP_NONE;
            FUNC_READ:  op = read_ok ? OP_READ : OP_NONE;
            FUNC_CLEAR: op = OP_CLEAR;
            default:    op = OP_NONE;
        endcase
    end

    assign push_entry = '{
        op:  op,
        idx: (func_reg == FUNC_READ) ? rc_reg : idx_wide[CELL_AW-1:0],
        z:   z_reg,
        cls: cls_reg,
        ret: ret_reg
    };

endmodule

`default_nettype wire

/* src/egb_queue.sv */
// ----------------------------------------------------------------------------
// egb_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module egb_queue
    import egb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  egb_entry_t  push_entry,
    input  logic        pop,
    output egb_entry_t  head,
    output egb_q_stat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    egb_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* src/egb_back.sv */
// ----------------------------------------------------------------------------
// egb_back
// Cell memory with occupancy bit: read-modify-write of points, cell reads,
// clearing sweeps and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module egb_back
    import egb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mode,
    input  egb_entry_t         head,
    input  egb_q_stat_t        q_stat,
    output logic               pop,
    output logic               init_busy,
    output logic               done,
    output logic signed [31:0] cell_height,
    output logic               cell_valid,
    output logic               accepted
);

    egb_back_state_t    state_reg, state_next;
    logic [CELL_AW-1:0] sweep_reg, sweep_next;
    logic               done_reg, done_next;
    logic               accepted_reg, accepted_next;
    logic               cell_valid_reg, cell_valid_next;
    logic [31:0]        cell_height_reg, cell_height_next;

    egb_entry_t cur_reg;
    logic [32:0] cell_mem [CELLS];
    logic [32:0] rd_data_reg;

    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [32:0]        mem_wdata;
    logic               sweep_last;

    logic               occ;
    logic signed [31:0] old_h, new_z;
    logic               lower, raise;

    assign sweep_last = (sweep_reg == CELL_AW'(CELLS - 1));
    assign occ        = rd_data_reg[32];
    assign old_h      = rd_data_reg[31:0];
    assign new_z      = cur_reg.z;
    assign lower      = (cur_reg.cls == GROUND_CLASS) && (new_z < old_h);
    assign raise      = (cur_reg.ret == FIRST_RETURN) && (new_z > old_h);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_INIT;
            sweep_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            done_reg     <= done_next;
        end
    end

    // next state, memory writes and result
    always_comb
    begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg.idx;
        mem_wdata        = {1'b1, cur_reg.z};
        done_next        = 1'b0;
        accepted_next    = 1'b0;
        cell_valid_next  = 1'b0;
        cell_height_next = 32'd0;
        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = B_IDLE;
                    sweep_next = '0;
                    if (state_reg == B_CLEAR)
                    begin
                        done_next     = 1'b1;
                        accepted_next = 1'b1;
                    end
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = (head.op == OP_CLEAR) ? B_CLEAR : B_EXEC;
                    sweep_next = '0;
                end
            end
            B_EXEC:
            begin
                state_next = B_IDLE;
                done_next  = 1'b1;
                case (cur_reg.op)
                    OP_ADD:
                    begin
                        accepted_next = 1'b1;
                        mem_we = !occ || (mode ? raise : lower);
                    end
                    OP_READ:
                    begin
                        accepted_next    = 1'b1;
                        cell_valid_next  = occ;
                        cell_height_next = occ ? old_h : 32'd0;
                    end
                    default:
                    begin
                        accepted_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // operation in progress and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        accepted_reg    <= accepted_next;
        cell_valid_reg  <= cell_valid_next;
        cell_height_reg <= cell_height_next;
    end

    // cell memory, registered read at the queue head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[head.idx];
    end

    assign init_busy   = (state_reg == B_INIT);
    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign cell_valid  = cell_valid_reg;
    assign cell_height = cell_height_reg;

`ifndef NO_ASSERTIONS
    // execute always ends in a result and a return to idle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EXEC) |=> (done_reg && state_reg == B_IDLE))
        else $error("execute not followed by a result");

    // a valid cell is only reported on an accepted word
    a_valid_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && cell_valid_reg) |-> accepted_reg)
        else $error("cell valid without accepted");

    // nothing taken from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // no result word while the memory is being swept after reset
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_INIT) |=> !done_reg)
        else $error("result during reset sweep");
`endif

endmodule

`default_nettype wire

/* src/elevation_grid_binner.sv */
// ----------------------------------------------------------------------------
// elevation_grid_binner
// Bins lidar points into a grid of cells and keeps a terrain or surface
// height per cell.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. After reset busy stays
// high while the cell memory is swept clear. An add-point word keeps the
// front busy from acceptance to the next acceptance while it classifies the
// offsets, runs the divider that resolves two quotient bits a cycle for x
// and y together, and queues it, waiting while the queue is full. Reads,
// clears and undefined codes are queued without classifying or dividing.
// The back side handles a word by a registered memory read, then the update,
// and a clear sweeps the memory one cell a cycle; a two-word queue lets the
// front carry on meanwhile. Each result is a one-cycle done pulse with its
// fields and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module elevation_grid_binner
    import egb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [7:0]         point_class,
    input  logic [3:0]         return_number,
    input  logic [13:0]        read_cell,
    output logic               done,
    output logic signed [31:0] cell_height,
    output logic               cell_valid,
    output logic               accepted,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    egb_cfg_t    cfg;
    egb_q_stat_t q_stat;
    egb_entry_t  push_entry;
    egb_entry_t  head;
    logic        push;
    logic        pop;
    logic        front_idle;
    logic        init_busy;
    logic        take;

    // word acceptance
    assign busy = !front_idle || init_busy;
    assign take = start && !busy;

    egb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    egb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .func          (func),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .point_class   (point_class),
        .return_number (return_number),
        .read_cell     (read_cell[CELL_AW-1:0]),
        .cfg           (cfg),
        .q_stat        (q_stat),
        .idle          (front_idle),
        .push          (push),
        .push_entry    (push_entry)
    );

    egb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    egb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (cfg.mode),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .cell_height (cell_height),
        .cell_valid  (cell_valid),
        .accepted    (accepted)
    );

endmodule

`default_nettype wire
